// ----- rtl/core/ppseq_pkg.sv -----
package ppseq_pkg;

  localparam int unsigned MsWidth       = 16;
  localparam int unsigned CountsWidth   = 12;
  localparam int unsigned LockWidth     = 8;
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned StateWidth    = 2;

  localparam int unsigned StrobeMs     = 100;
  localparam int unsigned PreBlinkMs   = 20;
  localparam int unsigned FaultBlinkMs = 200;

  localparam int unsigned StrobeCntWidth = $clog2(StrobeMs);
  localparam int unsigned PreCntWidth    = $clog2(PreBlinkMs);
  localparam int unsigned FaultCntWidth  = $clog2(FaultBlinkMs);

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_PRECHARGE_MS  = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_MAX_PRE_COUNT = 1'b1;

  // Reported power state codes.
  localparam logic [StateWidth-1:0] PSTATE_OFF   = 2'd0;
  localparam logic [StateWidth-1:0] PSTATE_PRE   = 2'd1;
  localparam logic [StateWidth-1:0] PSTATE_ON    = 2'd2;
  localparam logic [StateWidth-1:0] PSTATE_FAULT = 2'd3;

  localparam logic [MsWidth-1:0] PRECHARGE_MS_RST  = 16'd100;
  localparam logic [CountsWidth-1:0] MAX_COUNT_RST = 12'd2048;

  typedef struct packed {
    logic                   switch_on;
    logic [CountsWidth-1:0] voltage_sample;
    logic                   lock_cmd_valid;
    logic [LockWidth-1:0]   lock_cmd_time;
  } in_item_t;

  typedef struct packed {
    logic                  fet_main_on;
    logic                  fet_precharge_on;
    logic                  led_level;
    logic                  status_strobe;
    logic                  status_switch;
    logic [LockWidth-1:0]  status_lock;
    logic [StateWidth-1:0] power_state;
  } out_item_t;

  // Time-base status for the current tick.
  typedef struct packed {
    logic strobe;
    logic pre_blink;
    logic fault_blink;
  } tick_t;

endpackage

// ----- rtl/core/ppseq_if.sv -----
interface ppseq_in_if;
  import ppseq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   switch_on;
  logic [CountsWidth-1:0] voltage_sample;
  logic                   lock_cmd_valid;
  logic [LockWidth-1:0]   lock_cmd_time;

  modport source (output valid, switch_on, voltage_sample, lock_cmd_valid, lock_cmd_time,
                  input ready);
  modport sink (input valid, switch_on, voltage_sample, lock_cmd_valid, lock_cmd_time,
                output ready);
endinterface

interface ppseq_out_if;
  import ppseq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  fet_main_on;
  logic                  fet_precharge_on;
  logic                  led_level;
  logic                  status_strobe;
  logic                  status_switch;
  logic [LockWidth-1:0]  status_lock;
  logic [StateWidth-1:0] power_state;

  modport source (output valid, fet_main_on, fet_precharge_on, led_level, status_strobe,
                  status_switch, status_lock, power_state, input ready);
  modport sink (input valid, fet_main_on, fet_precharge_on, led_level, status_strobe,
                status_switch, status_lock, power_state, output ready);
endinterface

// ----- rtl/core/ppseq_timebase.sv -----
module ppseq_timebase
  import ppseq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  output tick_t tick
);

  logic [TimeWidth-1:0]      ms_count_r, ms_count_nxt;
  logic                      wrapped_r, wrapped_nxt;
  logic [StrobeCntWidth-1:0] strobe_cnt_r, strobe_cnt_nxt;
  logic [PreCntWidth-1:0]    pre_cnt_r, pre_cnt_nxt;
  logic                      pre_ph_r, pre_ph_nxt;
  logic [FaultCntWidth-1:0]  fault_cnt_r, fault_cnt_nxt;
  logic                      fault_ph_r, fault_ph_nxt;

  localparam logic [StrobeCntWidth-1:0] StrobeLast = StrobeCntWidth'(StrobeMs - 1);
  localparam logic [PreCntWidth-1:0]    PreLast    = PreCntWidth'(PreBlinkMs - 1);
  localparam logic [FaultCntWidth-1:0]  FaultLast  = FaultCntWidth'(FaultBlinkMs - 1);

  // The sub-counters track the residues of the tick time, so no divider is needed.
  assign tick.strobe      = (strobe_cnt_r == '0) && ((ms_count_r != '0) || wrapped_r);
  assign tick.pre_blink   = pre_ph_r;
  assign tick.fault_blink = fault_ph_r;

  always_comb begin
    ms_count_nxt   = ms_count_r;
    wrapped_nxt    = wrapped_r;
    strobe_cnt_nxt = strobe_cnt_r;
    pre_cnt_nxt    = pre_cnt_r;
    pre_ph_nxt     = pre_ph_r;
    fault_cnt_nxt  = fault_cnt_r;
    fault_ph_nxt   = fault_ph_r;
    if (advance) begin
      ms_count_nxt = ms_count_r + 1'b1;
      if (ms_count_r == '1) begin
        // The time wraps to zero. The wrap point is not a multiple of the periods, so
        // every residue and phase restarts from zero here.
        wrapped_nxt    = 1'b1;
        strobe_cnt_nxt = '0;
        pre_cnt_nxt    = '0;
        pre_ph_nxt     = 1'b0;
        fault_cnt_nxt  = '0;
        fault_ph_nxt   = 1'b0;
      end else begin
        strobe_cnt_nxt = (strobe_cnt_r == StrobeLast) ? '0 : strobe_cnt_r + 1'b1;
        if (pre_cnt_r == PreLast) begin
          pre_cnt_nxt = '0;
          pre_ph_nxt  = ~pre_ph_r;
        end else begin
          pre_cnt_nxt = pre_cnt_r + 1'b1;
        end
        if (fault_cnt_r == FaultLast) begin
          fault_cnt_nxt = '0;
          fault_ph_nxt  = ~fault_ph_r;
        end else begin
          fault_cnt_nxt = fault_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_count_r   <= '0;
      wrapped_r    <= 1'b0;
      strobe_cnt_r <= '0;
      pre_cnt_r    <= '0;
      pre_ph_r     <= 1'b0;
      fault_cnt_r  <= '0;
      fault_ph_r   <= 1'b0;
    end else begin
      ms_count_r   <= ms_count_nxt;
      wrapped_r    <= wrapped_nxt;
      strobe_cnt_r <= strobe_cnt_nxt;
      pre_cnt_r    <= pre_cnt_nxt;
      pre_ph_r     <= pre_ph_nxt;
      fault_cnt_r  <= fault_cnt_nxt;
      fault_ph_r   <= fault_ph_nxt;
    end
  end

endmodule

// ----- rtl/core/ppseq_ctrl.sv -----
module ppseq_ctrl
  import ppseq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_wdata,
  input  logic                     advance,
  input  in_item_t                 item,
  input  tick_t                    tick,
  output out_item_t                result
);

  typedef enum logic [3:0] {
    MODE_OFF   = 4'b0001,
    MODE_PRE   = 4'b0010,
    MODE_ON    = 4'b0100,
    MODE_FAULT = 4'b1000
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [MsWidth-1:0]     elapsed_r, elapsed_nxt;
  logic [LockWidth-1:0]   lock_r, lock_nxt;
  logic                   last_sw_r;
  logic [MsWidth-1:0]     precharge_ms_r;
  logic [CountsWidth-1:0] max_counts_r;
  logic                   pre_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precharge_ms_r <= PRECHARGE_MS_RST;
      max_counts_r   <= MAX_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRECHARGE_MS:  precharge_ms_r <= cfg_wdata;
        CFG_MAX_PRE_COUNT: max_counts_r   <= cfg_wdata[CountsWidth-1:0];
        default: ;
      endcase
    end
  end

  assign pre_done = (mode_r == MODE_PRE) && (elapsed_r >= precharge_ms_r);

  always_comb begin
    elapsed_nxt = elapsed_r;
    if (mode_r == MODE_PRE && elapsed_r != '1) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end

    // Decrement at the status boundary first, then a nonzero command overrides.
    lock_nxt = lock_r;
    if (tick.strobe && lock_r != '0) begin
      lock_nxt = lock_r - 1'b1;
    end
    if (item.lock_cmd_valid && item.lock_cmd_time != '0) begin
      lock_nxt = item.lock_cmd_time;
    end

    mode_nxt = mode_r;
    if (item.switch_on) begin
      if (mode_r == MODE_OFF) begin
        mode_nxt    = MODE_PRE;
        elapsed_nxt = '0;
      end else if (pre_done) begin
        mode_nxt = (item.voltage_sample > max_counts_r) ? MODE_FAULT : MODE_ON;
      end
    end else if (lock_nxt == '0) begin
      mode_nxt = MODE_OFF;
    end
  end

  always_comb begin
    result.status_strobe    = tick.strobe;
    result.status_switch    = last_sw_r;
    result.status_lock      = lock_r;
    result.fet_main_on      = 1'b0;
    result.fet_precharge_on = 1'b0;
    result.led_level        = 1'b1;
    result.power_state      = PSTATE_OFF;
    unique case (mode_r)
      MODE_PRE: begin
        result.fet_precharge_on = 1'b1;
        result.led_level        = tick.pre_blink;
        result.power_state      = PSTATE_PRE;
      end
      MODE_ON: begin
        result.fet_main_on      = 1'b1;
        result.fet_precharge_on = 1'b1;
        result.led_level        = 1'b0;
        result.power_state      = PSTATE_ON;
      end
      MODE_FAULT: begin
        result.led_level   = tick.fault_blink;
        result.power_state = PSTATE_FAULT;
      end
      default: begin
        result.power_state = PSTATE_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OFF;
      elapsed_r <= '0;
      lock_r    <= '0;
      last_sw_r <= 1'b0;
    end else if (advance) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      lock_r    <= lock_nxt;
      last_sw_r <= item.switch_on;
    end
  end

endmodule

// ----- rtl/core/ppseq_outbuf.sv -----
module ppseq_outbuf
  import ppseq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      push_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      pop;

  assign push_ready = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_item   = out_data_r;
  assign pop        = out_valid_r & out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// ----- rtl/core/precharge_power_sequencer_core.sv -----
// An accepted tick's result beat is registered into a two-entry output buffer that
// absorbs a stalled sink. Throughput: one tick beat per clock cycle while the skid entry
// is free, set by the single registered update of mode, lock and time-base registers.
// Reset: synchronous, active low; the sequencer returns to off with zero lock time and
// tick time, and the configuration registers return to 100 ms and 2048 counts.
module precharge_power_sequencer_core
  import ppseq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  ppseq_in_if.sink                 in_ch,
  ppseq_out_if.source              out_ch,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_wdata
);

  in_item_t  in_item;
  out_item_t result;
  out_item_t out_item;
  tick_t     tick;
  logic      in_ready;
  logic      accept;

  // Gather the tick beat into one struct.
  assign in_item.switch_on      = in_ch.switch_on;
  assign in_item.voltage_sample = in_ch.voltage_sample;
  assign in_item.lock_cmd_valid = in_ch.lock_cmd_valid;
  assign in_item.lock_cmd_time  = in_ch.lock_cmd_time;

  // The input side only waits when both output buffer entries are full, so ready does
  // not depend combinationally on the result side.
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid & in_ready;

  // Millisecond time base: tracks the tick time and its phases within the status
  // period and the two LED blink periods.
  ppseq_timebase u_timebase (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .tick    (tick)
  );

  // Mode sequencing, precharge timer, lock countdown and configuration registers.
  // The result is formed from the state at the start of the tick.
  ppseq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (accept),
    .item      (in_item),
    .tick      (tick),
    .result    (result)
  );

  // Result register with a skid entry behind it.
  ppseq_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_item  (result),
    .push_ready (in_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_item   (out_item)
  );

  assign out_ch.fet_main_on      = out_item.fet_main_on;
  assign out_ch.fet_precharge_on = out_item.fet_precharge_on;
  assign out_ch.led_level        = out_item.led_level;
  assign out_ch.status_strobe    = out_item.status_strobe;
  assign out_ch.status_switch    = out_item.status_switch;
  assign out_ch.status_lock      = out_item.status_lock;
  assign out_ch.power_state      = out_item.power_state;

endmodule

// ----- verif/tb_precharge_power_sequencer_core.sv -----
module tb_precharge_power_sequencer_core;
  import ppseq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A gap this long with no beat on either channel means the block has hung.
  localparam int unsigned StallLimit = 2000;
  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int unsigned HoldCycles = 80;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_wdata;

  ppseq_in_if  in_ch();
  ppseq_out_if out_ch();

  precharge_power_sequencer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Percent of cycles in which the tick sender and the status receiver sit idle.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  logic        hold_request;

  // Status beats predicted for accepted ticks, oldest first.
  out_item_t   expected_status[$];
  int unsigned mismatches;
  int unsigned status_beats;

  // Shadow of the sequencer: its configuration and its running state.
  logic [MsWidth-1:0]     cfg_pre_ms;
  logic [CountsWidth-1:0] cfg_max_cnt;
  logic [StateWidth-1:0]  seq_mode;
  logic [TimeWidth-1:0]   seq_time;
  logic [MsWidth-1:0]     seq_pre_elapsed;
  logic [LockWidth-1:0]   seq_lock;
  logic                   seq_last_sw;
  logic                   seq_wrapped;

  // Advances the shadow sequencer by one millisecond tick and returns the status beat
  // that the tick produces. All outputs describe the mode held at the start of the tick.
  function automatic out_item_t step_sequencer(input in_item_t tk);
    out_item_t             st;
    logic [StateWidth-1:0] cur;
    logic [TimeWidth-1:0]  t;
    logic [TimeWidth-1:0]  blink;
    logic                  pre_done;
    t        = seq_time;
    cur      = seq_mode;
    pre_done = 1'b0;
    st       = '0;
    st.status_switch = seq_last_sw;
    st.status_lock   = seq_lock;
    st.power_state   = cur;

    // The precharge decision uses the elapsed time of the previous tick; the count
    // saturates so that the longest precharge setting still completes.
    if (cur == PSTATE_PRE) begin
      pre_done = (seq_pre_elapsed >= cfg_pre_ms);
      if (seq_pre_elapsed != '1) seq_pre_elapsed = seq_pre_elapsed + 1'b1;
    end

    // The 100 ms boundary decrements the lock before a new command can load it. The
    // very first tick after reset is not a boundary unless the time base has wrapped.
    if ((t % StrobeMs) == 0 && (t != 0 || seq_wrapped)) begin
      st.status_strobe = 1'b1;
      if (seq_lock != 0) seq_lock = seq_lock - 1'b1;
    end
    if (tk.lock_cmd_valid && tk.lock_cmd_time != 0) seq_lock = tk.lock_cmd_time;

    case (cur)
      PSTATE_PRE: begin
        blink = t / PreBlinkMs;
        st.led_level        = blink[0];
        st.fet_precharge_on = 1'b1;
      end
      PSTATE_ON: begin
        st.led_level        = 1'b0;
        st.fet_main_on      = 1'b1;
        st.fet_precharge_on = 1'b1;
      end
      PSTATE_FAULT: begin
        blink = t / FaultBlinkMs;
        st.led_level = blink[0];
      end
      default: begin
        st.led_level = 1'b1;
      end
    endcase

    // Fault is left only through the switch-off path, once the lock has run out.
    seq_last_sw = tk.switch_on;
    if (tk.switch_on) begin
      if (cur == PSTATE_OFF) begin
        seq_mode        = PSTATE_PRE;
        seq_pre_elapsed = '0;
      end else if (cur == PSTATE_PRE && pre_done) begin
        seq_mode = (tk.voltage_sample > cfg_max_cnt) ? PSTATE_FAULT : PSTATE_ON;
      end
    end else if (seq_lock == 0) begin
      seq_mode = PSTATE_OFF;
    end

    seq_time = t + 1'b1;
    if (seq_time == 0) seq_wrapped = 1'b1;
    return st;
  endfunction

  function automatic in_item_t tick_of(input logic sw, input logic [CountsWidth-1:0] smp,
                                       input logic cv, input logic [LockWidth-1:0] ct);
    in_item_t tk;
    tk.switch_on      = sw;
    tk.voltage_sample = smp;
    tk.lock_cmd_valid = cv;
    tk.lock_cmd_time  = ct;
    return tk;
  endfunction

  // Random lock command content: valid commands mostly ask for short lock times so that
  // the switch-off path actually reaches off, with zero and long requests mixed in.
  function automatic in_item_t make_tick(input logic sw, input logic [CountsWidth-1:0] smp,
                                         input int unsigned cmd_pct);
    logic                 cv;
    logic [LockWidth-1:0] ct;
    cv = ($urandom_range(99) < cmd_pct);
    if (cv && $urandom_range(15) != 0) ct = LockWidth'($urandom_range(3));
    else ct = LockWidth'($urandom_range(255));
    return tick_of(sw, smp, cv, ct);
  endfunction

  // Offers one tick beat, after a random number of idle cycles, and records the status
  // beat it must produce at the edge where it is taken. Entered and left just after a
  // falling edge; valid stays high on exit so that back-to-back beats need no toggle.
  task automatic send_tick(input in_item_t tk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.switch_on      <= tk.switch_on;
    in_ch.voltage_sample <= tk.voltage_sample;
    in_ch.lock_cmd_valid <= tk.lock_cmd_valid;
    in_ch.lock_cmd_time  <= tk.lock_cmd_time;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_status.push_back(step_sequencer(tk));
    @(negedge clk);
  endtask

  // Stops offering ticks and waits until every status beat has come back and the block is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  // The write enable drops for one cycle before the task returns, so that back-to-back
  // writes never drive it twice at the same falling edge.
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_PRECHARGE_MS:  cfg_pre_ms  = val[MsWidth-1:0];
      CFG_MAX_PRE_COUNT: cfg_max_cnt = val[CountsWidth-1:0];
      default: ;
    endcase
  endtask

  // Runs on the reset configuration. The first tick has time zero and raises no strobe,
  // and a lock command with time zero on it must be ignored. A sample one count above
  // the default threshold, held past the default precharge time, ends in fault; the
  // hold spans the first 100 ms boundary. Fault persists with the switch on and falls
  // back to off as soon as the switch is released with no lock time left.
  task automatic test_power_up_defaults();
    send_tick(tick_of(1'b0, 12'hFFF, 1'b1, 8'd0));
    repeat (105) send_tick(tick_of(1'b1, 12'd2049, 1'b0, 8'hFF));
    repeat (3) send_tick(tick_of(1'b0, 12'd0, 1'b0, 8'd0));
  endtask

  // Zero precharge time completes on the tick after precharging starts. The threshold is
  // a strict compare, so a full-scale sample against a full-scale threshold powers on,
  // and against a zero threshold any nonzero sample faults while zero powers on.
  task automatic test_threshold_extremes();
    settle();
    write_reg(CFG_PRECHARGE_MS, '0);
    write_reg(CFG_MAX_PRE_COUNT, CfgDataWidth'(12'hFFF));
    repeat (3) send_tick(tick_of(1'b1, 12'hFFF, 1'b0, 8'd0));
    repeat (2) send_tick(tick_of(1'b0, 12'hFFF, 1'b0, 8'd0));
    settle();
    write_reg(CFG_MAX_PRE_COUNT, '0);
    repeat (3) send_tick(tick_of(1'b1, 12'd0, 1'b0, 8'd0));
    send_tick(tick_of(1'b0, 12'd0, 1'b0, 8'd0));
    repeat (3) send_tick(tick_of(1'b1, 12'd1, 1'b0, 8'd0));
    repeat (2) send_tick(tick_of(1'b0, 12'd1, 1'b0, 8'd0));
  endtask

  // A lock of one unit holds the block on with the switch released. At the boundary the
  // decrement to zero comes first and a new command in the same tick reloads the lock,
  // so the block must stay on. A full-scale command followed by a short one checks the
  // overwrite, and the last boundary releases the block to off.
  task automatic test_lock_ordering();
    settle();
    write_reg(CFG_MAX_PRE_COUNT, CfgDataWidth'(12'hFFF));
    repeat (2) send_tick(tick_of(1'b1, 12'd100, 1'b0, 8'd0));
    send_tick(tick_of(1'b1, 12'd100, 1'b1, 8'd1));
    while (seq_time % StrobeMs != 0) send_tick(tick_of(1'b0, 12'd7, 1'b0, 8'd0));
    send_tick(tick_of(1'b0, 12'd7, 1'b1, 8'd3));
    send_tick(tick_of(1'b0, 12'd7, 1'b1, 8'd0));
    send_tick(tick_of(1'b1, 12'd7, 1'b1, 8'hFF));
    send_tick(tick_of(1'b1, 12'd7, 1'b1, 8'd1));
    while (seq_mode != PSTATE_OFF) send_tick(tick_of(1'b0, 12'd7, 1'b0, 8'd0));
    send_tick(tick_of(1'b0, 12'd7, 1'b0, 8'd0));
  endtask

  // A precharge time that spans several blink periods and a status boundary completes
  // only once it has been reached, with the elapsed count running the whole way.
  task automatic test_long_precharge();
    settle();
    write_reg(CFG_PRECHARGE_MS, CfgDataWidth'(150));
    write_reg(CFG_MAX_PRE_COUNT, CfgDataWidth'(MAX_COUNT_RST));
    send_tick(tick_of(1'b1, 12'd0, 1'b0, 8'd0));
    while (seq_mode != PSTATE_ON) begin
      send_tick(tick_of(1'b1, CountsWidth'($urandom_range(2048)), 1'b0, 8'd0));
    end
    repeat (3) send_tick(tick_of(1'b1, 12'hFFF, 1'b0, 8'd0));
    repeat (2) send_tick(tick_of(1'b0, 12'd0, 1'b0, 8'd0));
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so the output
  // buffer fills and the block must stall its input without losing a beat.
  task automatic test_output_stall();
    settle();
    write_reg(CFG_PRECHARGE_MS, CfgDataWidth'(2));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    repeat (40) begin
      send_tick(make_tick(1'($urandom_range(1)), CountsWidth'($urandom_range(4095)), 20));
    end
  endtask

  // Mostly complete power cycles: the switch is held for about the precharge time, with
  // samples close to the threshold so both endings occur, then released for a while.
  // Some holds are too short and abort the precharge. Lock-only stretches and fully
  // random noise make up the rest.
  task automatic test_random_sequences(input int unsigned n_items, input int unsigned src_pct,
                                       input int unsigned sink_pct,
                                       input logic [MsWidth-1:0] pre_ms,
                                       input logic [CountsWidth-1:0] max_cnt);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int          smp;
    settle();
    write_reg(CFG_PRECHARGE_MS, CfgDataWidth'(pre_ms));
    write_reg(CFG_MAX_PRE_COUNT, CfgDataWidth'(max_cnt));
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        len = pre_ms + $urandom_range(40);
        repeat (len) begin
          if ($urandom_range(2) == 0) smp = $urandom_range(4095);
          else smp = int'(max_cnt) + int'($urandom_range(4)) - 2;
          if (smp < 0) smp = 0;
          if (smp > 4095) smp = 4095;
          send_tick(make_tick(1'b1, smp[CountsWidth-1:0], 3));
          sent++;
        end
        len = $urandom_range(250, 1);
        repeat (len) begin
          send_tick(make_tick(1'b0, CountsWidth'($urandom_range(4095)), 3));
          sent++;
        end
      end else if (kind <= 7) begin
        len = $urandom_range(120, 1);
        repeat (len) begin
          send_tick(make_tick(1'b0, CountsWidth'($urandom_range(4095)), 10));
          sent++;
        end
      end else begin
        repeat (20) begin
          send_tick(make_tick(1'($urandom_range(1)), CountsWidth'($urandom_range(4095)), 30));
          sent++;
        end
      end
    end
  endtask

  // Status receiver. A hold request from a test starts a long hold-off counted here;
  // otherwise ready follows the current idle percentage.
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Every status beat taken is compared with the oldest prediction. A beat with nothing
  // predicted is a failure as well.
  initial begin
    out_item_t got;
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.fet_main_on      = out_ch.fet_main_on;
        got.fet_precharge_on = out_ch.fet_precharge_on;
        got.led_level        = out_ch.led_level;
        got.status_strobe    = out_ch.status_strobe;
        got.status_switch    = out_ch.status_switch;
        got.status_lock      = out_ch.status_lock;
        got.power_state      = out_ch.power_state;
        if (expected_status.size() == 0) begin
          if (mismatches < 10) begin
            $display("status beat %0d arrived with none expected", status_beats);
          end
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display({"status beat %0d mismatch: exp main=%b pre=%b led=%b strobe=%b",
                        " sw=%b lock=%0d state=%0d"},
                       status_beats, want.fet_main_on, want.fet_precharge_on, want.led_level,
                       want.status_strobe, want.status_switch, want.status_lock,
                       want.power_state);
              $display("  got main=%b pre=%b led=%b strobe=%b sw=%b lock=%0d state=%0d",
                       got.fet_main_on, got.fet_precharge_on, got.led_level, got.status_strobe,
                       got.status_switch, got.status_lock, got.power_state);
            end
            mismatches++;
          end
        end
        status_beats++;
      end
    end
  end

  // Watchdog: the run ends if neither channel moves a beat for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.switch_on      = 1'b0;
    in_ch.voltage_sample = '0;
    in_ch.lock_cmd_valid = 1'b0;
    in_ch.lock_cmd_time  = '0;
    src_idle_pct         = 0;
    sink_idle_pct        = 0;
    hold_request         = 1'b0;
    mismatches           = 0;
    status_beats         = 0;
    cfg_pre_ms           = PRECHARGE_MS_RST;
    cfg_max_cnt          = MAX_COUNT_RST;
    seq_mode             = PSTATE_OFF;
    seq_time             = '0;
    seq_pre_elapsed      = '0;
    seq_lock             = '0;
    seq_last_sw          = 1'b0;
    seq_wrapped          = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_power_up_defaults();
    test_threshold_extremes();
    test_lock_ordering();
    test_long_precharge();
    test_output_stall();
    // Three random phases: sender lightly idle and receiver mostly stalled, the reverse,
    // then both at full rate. Each uses a different precharge time and threshold.
    test_random_sequences(170, 25, 67, 16'd5, 12'd2048);
    test_random_sequences(170, 67, 25, 16'd0, 12'd0);
    test_random_sequences(170, 0, 0, 16'd17, 12'hFFF);
    settle();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
